/* rtl/imhq_pkg.sv */
// shared types and constants for the indexed min-heap queue
// no dependencies
package imhq_pkg;

  localparam int CAPACITY   = 1024;
  localparam int NODE_COUNT = 2048;
  localparam int KEY_BITS   = 16;

  localparam int SLOT_W  = $clog2(CAPACITY);
  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int COUNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W   = COUNT_W + 1;

  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_EXTRACT  = 2'd1,
    OP_DECREASE = 2'd2,
    OP_NONE     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_ABSENT   = 2'd3
  } status_t;

  typedef struct packed {
    logic [NODE_W-1:0]   node;
    logic [KEY_BITS-1:0] key;
  } entry_t;

  // node map word: present flag and slot
  typedef struct packed {
    logic              present;
    logic [SLOT_W-1:0] slot;
  } map_t;

endpackage

/* rtl/indexed_min_heap_queue_core.sv */
// indexed binary min-heap queue: slot memory, node map memory and sift control
// depends on imhq_pkg
// sift-up moves through S_UP and S_UPW per level; sift-down through S_DN, S_DNL and,
//   when a right child exists, S_DNR per level, with one slot memory read per step
// one item in work at a time; the next item is taken while a result waits
// reset: synchronous, active low; then a pass over all 2048 node map words clears
//   the node map, during which no item is taken
module indexed_min_heap_queue_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   in_operation,
  input  logic [imhq_pkg::NODE_W-1:0]  in_node_id,
  input  logic [15:0]                  in_key,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [1:0]                   out_status,
  output logic [imhq_pkg::NODE_W-1:0]  out_node_id,
  output logic [15:0]                  out_key,
  output logic [imhq_pkg::COUNT_W-1:0] out_entry_count,
  output logic                         out_heap_empty
);
  import imhq_pkg::*;

  typedef enum logic [10:0] {
    S_CLR  = 11'b00000000001,
    S_IDLE = 11'b00000000010,
    S_LOOK = 11'b00000000100,
    S_UP   = 11'b00000001000,
    S_UPW  = 11'b00000010000,
    S_EX0  = 11'b00000100000,
    S_EX1  = 11'b00001000000,
    S_DN   = 11'b00010000000,
    S_DNL  = 11'b00100000000,
    S_DNR  = 11'b01000000000,
    S_FIN  = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;

  // memories
  entry_t            slot_mem [CAPACITY];
  map_t              map_mem  [NODE_COUNT];
  entry_t            slot_rdata_r;
  map_t              map_rdata_r;
  logic              slot_we, slot_re, map_we, map_re;
  logic [SLOT_W-1:0] slot_waddr, slot_raddr;
  entry_t            slot_wdata;
  logic [NODE_W-1:0] map_waddr, map_raddr;
  map_t              map_wdata;

  always_ff @(posedge clk) begin
    if (slot_we) slot_mem[slot_waddr] <= slot_wdata;
    if (slot_re) slot_rdata_r <= slot_mem[slot_raddr];
    if (map_we) map_mem[map_waddr] <= map_wdata;
    if (map_re) map_rdata_r <= map_mem[map_raddr];
  end

  op_t                 op_r, op_nxt;
  logic [SLOT_W-1:0]   pos_r, pos_nxt;
  entry_t              ent_r, ent_nxt;
  entry_t              left_r, left_nxt;
  logic [COUNT_W-1:0]  cnt_r, cnt_nxt;
  logic [NODE_W-1:0]   clr_r, clr_nxt;
  status_t             res_status_r, res_status_nxt;
  entry_t              res_ent_r, res_ent_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_status_r, out_status_nxt;
  entry_t              out_ent_r, out_ent_nxt;
  logic [COUNT_W-1:0]  out_cnt_r, out_cnt_nxt;

  logic [IDX_W-1:0]  left_idx, right_idx;
  logic [SLOT_W-1:0] parent_idx;
  logic              left_better;
  logic [KEY_BITS-1:0] best_key;

  assign left_idx   = {1'b0, pos_r, 1'b0} + IDX_W'(1);
  assign right_idx  = {1'b0, pos_r, 1'b0} + IDX_W'(2);
  assign parent_idx = SLOT_W'((pos_r - SLOT_W'(1)) >> 1);
  assign left_better = left_r.key < ent_r.key;
  assign best_key    = left_better ? left_r.key : ent_r.key;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt      = state_r;
    op_nxt         = op_r;
    pos_nxt        = pos_r;
    ent_nxt        = ent_r;
    left_nxt       = left_r;
    cnt_nxt        = cnt_r;
    clr_nxt        = clr_r;
    res_status_nxt = res_status_r;
    res_ent_nxt    = res_ent_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_status_nxt = out_status_r;
    out_ent_nxt    = out_ent_r;
    out_cnt_nxt    = out_cnt_r;
    slot_we    = 1'b0;
    slot_waddr = pos_r;
    slot_wdata = ent_r;
    slot_re    = 1'b0;
    slot_raddr = '0;
    map_we     = 1'b0;
    map_waddr  = ent_r.node;
    map_wdata  = '{present: 1'b1, slot: pos_r};
    map_re     = 1'b0;
    map_raddr  = in_node_id;

    unique case (state_r)
      S_CLR: begin
        map_we    = 1'b1;
        map_waddr = clr_r;
        map_wdata = '0;
        clr_nxt   = clr_r + NODE_W'(1);
        if (clr_r == NODE_W'(NODE_COUNT - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          op_nxt         = op_t'(in_operation);
          ent_nxt        = '{node: in_node_id, key: in_key[KEY_BITS-1:0]};
          res_status_nxt = ST_OK;
          res_ent_nxt    = '0;
          case (op_t'(in_operation))
            OP_EXTRACT: begin
              if (cnt_r == '0) begin
                res_status_nxt = ST_EMPTY;
                state_nxt      = S_FIN;
              end else begin
                slot_re    = 1'b1;
                slot_raddr = '0;
                state_nxt  = S_EX0;
              end
            end
            OP_NONE: state_nxt = S_FIN;
            default: begin
              map_re    = 1'b1;
              state_nxt = S_LOOK;
            end
          endcase
        end
      end
      S_LOOK: begin
        if (map_rdata_r.present) begin
          pos_nxt   = map_rdata_r.slot;
          state_nxt = S_UP;
        end else if (op_r == OP_DECREASE) begin
          res_status_nxt = ST_ABSENT;
          state_nxt      = S_FIN;
        end else if (cnt_r == COUNT_W'(CAPACITY)) begin
          res_status_nxt = ST_OVERFLOW;
          state_nxt      = S_FIN;
        end else begin
          pos_nxt   = SLOT_W'(cnt_r);
          cnt_nxt   = cnt_r + COUNT_W'(1);
          state_nxt = S_UP;
        end
      end
      S_UP: begin
        if (pos_r == '0) begin
          slot_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = parent_idx;
          state_nxt  = S_UPW;
        end
      end
      S_UPW: begin
        slot_we = 1'b1;
        map_we  = 1'b1;
        if (slot_rdata_r.key > ent_r.key) begin
          // parent moves down into the hole
          slot_wdata = slot_rdata_r;
          map_waddr  = slot_rdata_r.node;
          pos_nxt    = parent_idx;
          state_nxt  = S_UP;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_EX0: begin
        res_ent_nxt = slot_rdata_r;
        map_we      = 1'b1;
        map_waddr   = slot_rdata_r.node;
        map_wdata   = '0;
        slot_re     = 1'b1;
        slot_raddr  = SLOT_W'(cnt_r - COUNT_W'(1));
        state_nxt   = S_EX1;
      end
      S_EX1: begin
        ent_nxt = slot_rdata_r;
        cnt_nxt = cnt_r - COUNT_W'(1);
        pos_nxt = '0;
        if (cnt_r == COUNT_W'(1)) state_nxt = S_FIN;
        else state_nxt = S_DN;
      end
      S_DN: begin
        if (left_idx >= IDX_W'(cnt_r)) begin
          slot_we   = 1'b1;
          map_we    = 1'b1;
          state_nxt = S_FIN;
        end else begin
          slot_re    = 1'b1;
          slot_raddr = SLOT_W'(left_idx);
          state_nxt  = S_DNL;
        end
      end
      S_DNL: begin
        left_nxt = slot_rdata_r;
        if (right_idx < IDX_W'(cnt_r)) begin
          slot_re    = 1'b1;
          slot_raddr = SLOT_W'(right_idx);
          state_nxt  = S_DNR;
        end else begin
          slot_we = 1'b1;
          map_we  = 1'b1;
          if (slot_rdata_r.key < ent_r.key) begin
            slot_wdata = slot_rdata_r;
            map_waddr  = slot_rdata_r.node;
            pos_nxt    = SLOT_W'(left_idx);
            state_nxt  = S_DN;
          end else begin
            state_nxt = S_FIN;
          end
        end
      end
      S_DNR: begin
        slot_we = 1'b1;
        map_we  = 1'b1;
        if (slot_rdata_r.key < best_key) begin
          slot_wdata = slot_rdata_r;
          map_waddr  = slot_rdata_r.node;
          pos_nxt    = SLOT_W'(right_idx);
          state_nxt  = S_DN;
        end else if (left_better) begin
          slot_wdata = left_r;
          map_waddr  = left_r.node;
          pos_nxt    = SLOT_W'(left_idx);
          state_nxt  = S_DN;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        // hand over once the output register is free
        if (!out_valid_r || out_ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_ent_nxt    = res_ent_r;
          out_cnt_nxt    = cnt_r;
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    op_r         <= op_nxt;
    pos_r        <= pos_nxt;
    ent_r        <= ent_nxt;
    left_r       <= left_nxt;
    res_status_r <= res_status_nxt;
    res_ent_r    <= res_ent_nxt;
    out_status_r <= out_status_nxt;
    out_ent_r    <= out_ent_nxt;
    out_cnt_r    <= out_cnt_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_node_id     = out_ent_r.node;
  assign out_key         = 16'(out_ent_r.key);
  assign out_entry_count = out_cnt_r;
  assign out_heap_empty  = (out_cnt_r == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= COUNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_OVERFLOW |-> out_entry_count == COUNT_W'(CAPACITY))
    else $error("overflow reported with free slots");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_EMPTY |-> out_entry_count == '0)
    else $error("empty reported on non-empty heap");

  a_no_take_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CLR |-> !in_ready)
    else $error("input taken during map clear");

endmodule

/* dv/indexed_min_heap_queue_core_tb.sv */
// testbench for indexed_min_heap_queue_core: random and directed heap operations
// checked against an in-bench indexed min-heap predictor held in a scoreboard class
// depends on imhq_pkg and the core rtl
module indexed_min_heap_queue_core_tb;
  import imhq_pkg::*;

  typedef struct packed {
    status_t              status;
    logic [NODE_W-1:0]    node;
    logic [15:0]          key;
    logic [COUNT_W-1:0]   count;
    logic                 empty;
  } heap_result_t;

  class heap_scoreboard;
    logic [NODE_W-1:0]   hnode[CAPACITY];
    logic [KEY_BITS-1:0] hkey[CAPACITY];
    int                  where[NODE_COUNT];
    bit                  held[NODE_COUNT];
    int                  count;
    heap_result_t        pending[$];
    int                  errors;

    function void clear();
      foreach (held[i]) held[i] = 0;
      count = 0;
      errors = 0;
    endfunction

    function void swap_slots(int a, int b);
      logic [NODE_W-1:0]   n;
      logic [KEY_BITS-1:0] k;
      where[hnode[a]] = b;
      where[hnode[b]] = a;
      n = hnode[a]; hnode[a] = hnode[b]; hnode[b] = n;
      k = hkey[a]; hkey[a] = hkey[b]; hkey[b] = k;
    endfunction

    function void sift_up(int p);
      while (p != 0 && p < count && hkey[(p - 1) / 2] > hkey[p]) begin
        swap_slots(p, (p - 1) / 2);
        p = (p - 1) / 2;
      end
    endfunction

    function void sift_down(int p);
      int best;
      while (p < count) begin
        best = p;
        if (2 * p + 1 < count && hkey[2 * p + 1] < hkey[best]) best = 2 * p + 1;
        if (2 * p + 2 < count && hkey[2 * p + 2] < hkey[best]) best = 2 * p + 2;
        if (best == p) break;
        swap_slots(p, best);
        p = best;
      end
    endfunction

    function void note_transfer(op_t op, logic [NODE_W-1:0] id, logic [15:0] key);
      heap_result_t r;
      r = '0;
      r.status = ST_OK;
      if (op == OP_INSERT || op == OP_DECREASE) begin
        if (held[id]) begin
          hkey[where[id]] = key;
          sift_up(where[id]);
        end else if (op == OP_DECREASE) begin
          r.status = ST_ABSENT;
        end else if (count >= CAPACITY) begin
          r.status = ST_OVERFLOW;
        end else begin
          hnode[count] = id;
          hkey[count] = key;
          where[id] = count;
          held[id] = 1;
          count++;
          sift_up(count - 1);
        end
      end else if (op == OP_EXTRACT) begin
        if (count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.node = hnode[0];
          r.key = hkey[0];
          held[hnode[0]] = 0;
          if (count > 1) begin
            hnode[0] = hnode[count - 1];
            hkey[0] = hkey[count - 1];
            where[hnode[0]] = 0;
          end
          count--;
          sift_down(0);
        end
      end
      r.count = COUNT_W'(count);
      r.empty = (count == 0);
      pending.push_back(r);
    endfunction

    function void check_result(heap_result_t got);
      heap_result_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) $display("mismatch: expected %p actual %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0, out_ready = 0;
  logic in_ready, out_valid;
  logic [1:0] in_operation = 0;
  logic [NODE_W-1:0] in_node_id = 0;
  logic [15:0] in_key = 0;
  logic [1:0] out_status;
  logic [NODE_W-1:0] out_node_id;
  logic [15:0] out_key;
  logic [COUNT_W-1:0] out_entry_count;
  logic out_heap_empty;

  heap_scoreboard heap_sb = new();
  int cycles = 0;
  int stall_left = 0;
  bit quiet_sink = 0;

  always begin
    #10 clk = 1;
    #10 clk = 0;
  end

  indexed_min_heap_queue_core u_dut (.*);

  function automatic int gap_len();
    if ($urandom_range(0, 3) == 0) return 0;
    return ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60) : $urandom_range(0, 3);
  endfunction

  // result side: random stalls, a few long, check every transfer
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("status: fail");
      $finish;
    end
    if (rst_n) begin
      if (out_valid && out_ready)
        heap_sb.check_result('{status_t'(out_status), out_node_id, out_key,
                               out_entry_count, out_heap_empty});
      if (quiet_sink) begin
        out_ready <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready  <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= ($urandom_range(0, 7) != 0);
        if ($urandom_range(0, 63) == 0) stall_left <= $urandom_range(10, 50);
      end
    end
  end

  // valid stays up between back-to-back transfers, drops only for a gap
  task automatic send_op(op_t op, int id, int key);
    int g;
    g = quiet_sink ? 0 : gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_node_id <= NODE_W'(id);
    in_key <= 16'(key);
    do @(posedge clk); while (!in_ready);
    heap_sb.note_transfer(op, NODE_W'(id), 16'(key));
  endtask

  // random mix of inserts, extracts and decreases, with some random ops that may be the unused op
  task automatic heap_burst(int n, int id_span);
    int i;
    for (i = 0; i < n; i++)
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_op(OP_INSERT, $urandom_range(0, id_span), $urandom);
        5, 6, 7:       send_op(OP_EXTRACT, $urandom, $urandom);
        8:             send_op(OP_DECREASE, $urandom_range(0, id_span), $urandom_range(0, 4095));
        default:       send_op(op_t'($urandom_range(0, 3)), $urandom, $urandom);
      endcase
  endtask

  initial begin
    int i;
    heap_sb.clear();
    repeat (10) @(posedge clk);
    rst_n <= 1;
    // directed: empty extract, extremes, ties, absent, re-insert, unused op
    send_op(OP_EXTRACT, 0, 0);
    send_op(OP_DECREASE, 5, 1);
    send_op(OP_INSERT, 2047, 16'hffff);
    send_op(OP_INSERT, 0, 0);
    send_op(OP_INSERT, 1, 0);
    send_op(OP_INSERT, 1365, 16'h5555);
    send_op(OP_INSERT, 682, 16'haaaa);
    send_op(OP_DECREASE, 2047, 3);
    send_op(OP_DECREASE, 0, 16'hfff0);
    send_op(OP_INSERT, 682, 1);
    send_op(OP_NONE, 2047, 16'hffff);
    repeat (7) send_op(OP_EXTRACT, 0, 0);
    // fill to capacity and overflow, reach deep levels
    quiet_sink = 1;
    for (i = 0; i < CAPACITY; i++) send_op(OP_INSERT, i * 2 + (i & 1), $urandom);
    send_op(OP_INSERT, 2046, 7);
    send_op(OP_DECREASE, 2044, 0);
    repeat (100) send_op(OP_EXTRACT, 0, 0);
    quiet_sink = 0;
    heap_burst(150, 2047);
    heap_burst(50, 31);
    in_valid <= 0;
    while (heap_sb.pending.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (heap_sb.errors == 0 && heap_sb.pending.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
